### src/sb64fe_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helper functions of the base64 frame encoder
package sb64fe_pkg;

  localparam logic [7:0] HDR_FIRST_0 = 8'h06;
  localparam logic [7:0] HDR_FIRST_1 = 8'h09;
  localparam logic [7:0] HDR_NEXT_0  = 8'h04;
  localparam logic [7:0] HDR_NEXT_1  = 8'h14;
  localparam logic [7:0] NEWLINE     = 8'h0A;
  localparam logic [7:0] PAD_CHAR    = 8'h3D;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] LEN_MAX  = 16'd65533;

  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [7:0]  data;
    logic        sof;
    logic [15:0] field;
    logic        last;
    logic [15:0] crc;
  } qent_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] r;
    priority if (idx < 6'd26) r = {2'b00, idx} + 8'h41;
    else if (idx < 6'd52) r = {2'b00, idx} - 8'd26 + 8'h61;
    else if (idx < 6'd62) r = {2'b00, idx} - 8'd52 + 8'h30;
    else if (idx == 6'd62) r = 8'h2B;
    else r = 8'h2F;
    return r;
  endfunction

endpackage

### src/sb64fe_ifs.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for payload bytes and text characters
interface sb64fe_payload_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        start_of_frame;
  logic [15:0] payload_length;

  modport source (output valid, data_byte, start_of_frame, payload_length, input ready);
  modport sink (input valid, data_byte, start_of_frame, payload_length, output ready);
endinterface

interface sb64fe_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       end_of_frame;
  logic       last_of_run;

  modport source (output valid, out_char, end_of_frame, last_of_run, input ready);
  modport sink (input valid, out_char, end_of_frame, last_of_run, output ready);
endinterface

### src/sb64fe_front.sv
`timescale 1ns / 1ps
// front end: accepts payload bytes, tracks the frame, runs the crc, fills the queue
module sb64fe_front import sb64fe_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  sb64fe_payload_if.sink payload,
  input  logic          q_full,
  output logic          q_push,
  output qent_t         q_data
);

  logic [15:0] crc_start;
  logic [15:0] crc;
  logic [15:0] payload_left;
  logic        in_frame;

  logic        accept;
  logic [15:0] len_sat;
  logic [15:0] crc_next;
  logic        last_byte;

  assign payload.ready = !q_full;
  assign accept = payload.valid && payload.ready;

  always_comb begin
    priority if (payload.payload_length == 16'd0) len_sat = 16'd1;
    else if (payload.payload_length > LEN_MAX) len_sat = LEN_MAX;
    else len_sat = payload.payload_length;
  end

  assign crc_next = crc_byte(payload.start_of_frame ? crc_start : crc, payload.data_byte);
  assign last_byte = payload.start_of_frame ? (len_sat == 16'd1) : (payload_left == 16'd1);

  // bytes outside a frame are dropped here
  assign q_push = accept && (payload.start_of_frame || in_frame);

  assign q_data.data  = payload.data_byte;
  assign q_data.sof   = payload.start_of_frame;
  assign q_data.field = len_sat + 16'd2;
  assign q_data.last  = last_byte;
  assign q_data.crc   = crc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_start <= 16'd0;
      in_frame  <= 1'b0;
    end else begin
      if (cfg_we) begin
        crc_start <= cfg_wdata;
      end
      if (q_push) begin
        in_frame <= !last_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      crc          <= crc_next;
      payload_left <= (payload.start_of_frame ? len_sat : payload_left) - 16'd1;
    end
  end

endmodule

### src/sb64fe_queue.sv
`timescale 1ns / 1ps
// small register fifo between front and back
module sb64fe_queue import sb64fe_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  qent_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output qent_t head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qent_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full       = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

### src/sb64fe_back.sv
`timescale 1ns / 1ps
// back end: turns queued items into stream bytes, lines and base64 characters
module sb64fe_back import sb64fe_pkg::*; #(
  parameter int MAX_LINE_CHARS = 124,
  parameter int CHUNK_BYTES    = 12
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  qent_t          head_data,
  output logic           pop,
  sb64fe_text_if.source  text
);

  localparam int FCC  = 4 * ((CHUNK_BYTES + 2) / 3);
  localparam int LC_W = $clog2(MAX_LINE_CHARS + FCC + 1);
  localparam int CW   = LC_W + 1;
  localparam int CP_W = $clog2(CHUNK_BYTES);
  localparam int SW   = $clog2(CHUNK_BYTES + 1);
  localparam int PW   = SW + 7;

  localparam logic [2:0] OP_HDR0  = 3'd0;
  localparam logic [2:0] OP_HDR1  = 3'd1;
  localparam logic [2:0] OP_LENHI = 3'd2;
  localparam logic [2:0] OP_LENLO = 3'd3;
  localparam logic [2:0] OP_DATA  = 3'd4;
  localparam logic [2:0] OP_CRCHI = 3'd5;
  localparam logic [2:0] OP_CRCLO = 3'd6;
  localparam logic [2:0] OP_END   = 3'd7;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PLAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  // sequencer
  logic [1:0]       state;
  logic [2:0]       op;
  qent_t            ent;
  logic [CNT_W-1:0] cnt;

  // frame state
  logic [16:0]      remaining;
  logic [15:0]      group_bytes;
  logic [1:0]       gc;
  logic [CP_W-1:0]  chunk_pos;
  logic [LC_W-1:0]  line_chars;
  logic             line_nonempty;

  // character plan of the current stream byte
  logic             p_lit;
  logic [7:0]       p_lit_char;
  logic             p_brk;
  logic [23:0]      p_v;
  logic [2:0]       p_nd;
  logic [2:0]       p_nt;
  logic [3:0]       p_total;
  logic [3:0]       ci;

  // pending and output characters
  logic             pv;
  logic [7:0]       pend_char;
  logic             pend_eof;
  logic             out_valid;
  logic [7:0]       out_char;
  logic             out_eof;
  logic             out_last;

  logic [7:0]       pb;
  logic [SW-1:0]    s;
  logic [SW:0]      s_p2;
  logic [PW-1:0]    prod;
  logic [CW-1:0]    pad;
  logic             brk;
  logic             full;
  logic [15:0]      gb_a;
  logic [1:0]       gc_a;
  logic [1:0]       gc_n;
  logic             chunk_end;
  logic [16:0]      rem_n;
  logic             fin;
  logic             flush;
  logic [LC_W-1:0]  line_chars_a;
  logic [LC_W-1:0]  line_chars_n;
  logic [23:0]      v_n;
  logic [2:0]       nd_n;
  logic [2:0]       nt_n;
  logic [3:0]       total_n;
  logic [2:0]       next_op;

  logic [2:0]       j;
  logic [5:0]       sextet;
  logic [7:0]       ch;
  logic             ch_eof;

  logic             can_move;
  logic             keep;
  logic             emit_go;
  logic             fin_go;
  logic             move;
  logic             load;
  logic             plan_go;

  always_comb begin
    unique case (op)
      OP_LENHI: pb = ent.field[15:8];
      OP_LENLO: pb = ent.field[7:0];
      OP_CRCHI: pb = ent.crc[15:8];
      OP_CRCLO: pb = ent.crc[7:0];
      default:  pb = ent.data;
    endcase
  end

  // padded base64 size of the next chunk: 4 * ceil(s / 3)
  assign s    = (remaining < 17'(CHUNK_BYTES)) ? SW'(remaining) : SW'(CHUNK_BYTES);
  assign s_p2 = {1'b0, s} + (SW + 1)'(2);
  assign prod = PW'(s_p2) * PW'(43);
  assign pad  = CW'({prod[PW-1:7], 2'b00});

  assign brk = line_nonempty && (chunk_pos == '0)
               && (CW'(line_chars) + pad >= CW'(MAX_LINE_CHARS));

  assign full      = gc == 2'd2;
  assign gb_a      = {group_bytes[7:0], pb};
  assign gc_a      = full ? 2'd0 : gc + 2'd1;
  assign chunk_end = chunk_pos == CP_W'(CHUNK_BYTES - 1);
  assign rem_n     = remaining - 17'd1;
  assign fin       = rem_n == 17'd0;
  assign flush     = (chunk_end || fin) && (gc_a != 2'd0);
  assign gc_n      = (full || flush) ? 2'd0 : gc_a;

  assign line_chars_a = brk ? LC_W'(2) : line_chars;
  assign line_chars_n = chunk_end ? line_chars_a + LC_W'(FCC) : line_chars_a;

  always_comb begin
    priority if (full) begin
      v_n  = {group_bytes, pb};
      nd_n = 3'd4;
      nt_n = 3'd4;
    end else if (flush) begin
      v_n  = (gc_a == 2'd1) ? {pb, 16'h0000} : {group_bytes[7:0], pb, 8'h00};
      nd_n = {1'b0, gc_a} + 3'd1;
      nt_n = fin ? 3'd4 : {1'b0, gc_a} + 3'd1;
    end else begin
      v_n  = 24'd0;
      nd_n = 3'd0;
      nt_n = 3'd0;
    end
  end

  assign total_n = (brk ? 4'd3 : 4'd0) + {1'b0, nt_n} + {3'b000, fin};

  always_comb begin
    unique case (op)
      OP_HDR0:  next_op = OP_HDR1;
      OP_HDR1:  next_op = OP_LENHI;
      OP_LENHI: next_op = OP_LENLO;
      OP_LENLO: next_op = OP_DATA;
      OP_DATA:  next_op = ent.last ? OP_CRCHI : OP_END;
      OP_CRCHI: next_op = OP_CRCLO;
      default:  next_op = OP_END;
    endcase
  end

  // character at position ci of the plan
  assign j = ci[2:0] - (p_brk ? 3'd3 : 3'd0);

  always_comb begin
    unique case (j[1:0])
      2'd0:    sextet = p_v[23:18];
      2'd1:    sextet = p_v[17:12];
      2'd2:    sextet = p_v[11:6];
      default: sextet = p_v[5:0];
    endcase
  end

  always_comb begin
    ch_eof = 1'b0;
    priority if (p_lit) begin
      ch = p_lit_char;
    end else if (p_brk && (ci < 4'd3)) begin
      unique case (ci[1:0])
        2'd1:    ch = HDR_NEXT_0;
        2'd2:    ch = HDR_NEXT_1;
        default: ch = NEWLINE;
      endcase
    end else if (j < p_nt) begin
      ch = (j < p_nd) ? b64_char(sextet) : PAD_CHAR;
    end else begin
      ch     = NEWLINE;
      ch_eof = 1'b1;
    end
  end

  // one character is held back so the last one of an item can be marked
  assign can_move = !out_valid || text.ready;
  assign keep     = cnt < CNT_W'(MAX_RESULTS);
  assign emit_go  = (state == ST_EMIT) && (!keep || !pv || can_move);
  assign fin_go   = (state == ST_PLAN) && (op == OP_END) && (!pv || can_move);
  assign plan_go  = (state == ST_PLAN) && (op != OP_END);
  assign move     = (emit_go && keep && pv) || (fin_go && pv);
  assign load     = ((state == ST_IDLE) || fin_go) && head_valid;
  assign pop      = load;

  assign text.valid        = out_valid;
  assign text.out_char     = out_char;
  assign text.end_of_frame = out_eof;
  assign text.last_of_run  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      op            <= OP_END;
      cnt           <= '0;
      pv            <= 1'b0;
      out_valid     <= 1'b0;
      ci            <= 4'd0;
      p_total       <= 4'd0;
      remaining     <= 17'd0;
      gc            <= 2'd0;
      chunk_pos     <= '0;
      line_chars    <= '0;
      line_nonempty <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (head_valid) begin
            state <= ST_PLAN;
          end
        end
        ST_PLAN: begin
          if (fin_go) begin
            state <= head_valid ? ST_PLAN : ST_IDLE;
          end else if (plan_go) begin
            op <= next_op;
            ci <= 4'd0;
            if (op == OP_HDR0 || op == OP_HDR1) begin
              p_total <= 4'd1;
              state   <= ST_EMIT;
            end else begin
              p_total <= total_n;
              state   <= (total_n != 4'd0) ? ST_EMIT : ST_PLAN;
            end
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            ci <= ci + 4'd1;
            if (ci + 4'd1 == p_total) begin
              state <= ST_PLAN;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (load) begin
        op  <= head_data.sof ? OP_HDR0 : OP_DATA;
        cnt <= '0;
      end else if (emit_go && keep) begin
        cnt <= cnt + CNT_W'(1);
      end

      if (emit_go && keep) begin
        pv <= 1'b1;
      end else if (fin_go) begin
        pv <= 1'b0;
      end

      if (move) begin
        out_valid <= 1'b1;
      end else if (text.ready) begin
        out_valid <= 1'b0;
      end

      if (plan_go) begin
        if (op == OP_HDR0) begin
          remaining     <= {1'b0, ent.field} + 17'd2;
          gc            <= 2'd0;
          chunk_pos     <= '0;
          line_chars    <= LC_W'(2);
          line_nonempty <= 1'b0;
        end else if (op != OP_HDR1) begin
          remaining     <= rem_n;
          gc            <= gc_n;
          chunk_pos     <= chunk_end ? '0 : chunk_pos + CP_W'(1);
          line_chars    <= line_chars_n;
          line_nonempty <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent <= head_data;
    end
    if (plan_go) begin
      p_lit      <= (op == OP_HDR0) || (op == OP_HDR1);
      p_lit_char <= (op == OP_HDR0) ? HDR_FIRST_0 : HDR_FIRST_1;
      p_brk      <= (op == OP_HDR0 || op == OP_HDR1) ? 1'b0 : brk;
      p_v        <= v_n;
      p_nd       <= nd_n;
      p_nt       <= nt_n;
      if (op != OP_HDR0 && op != OP_HDR1) begin
        group_bytes <= gb_a;
      end
    end
    if (emit_go && keep) begin
      pend_char <= ch;
      pend_eof  <= ch_eof;
    end
    if (move) begin
      out_char <= pend_char;
      out_eof  <= pend_eof;
      out_last <= fin_go;
    end
  end

endmodule

### src/serial_base64_frame_encoder_unit.sv
`timescale 1ns / 1ps
// top level: payload bytes in, framed base64 text lines with crc out
// throughput: a byte is taken every cycle while the 4-item queue has room; the back sequencer
//   plans each stream byte, emits its characters one by one and then closes the item before
//   it pops the next one; a frame's first byte also carries the header and length bytes
// reset: synchronous, clears the queue, the sequencer and the crc start value, block idle
module serial_base64_frame_encoder_unit import sb64fe_pkg::*; #(
  parameter int MAX_LINE_CHARS = 124,
  parameter int CHUNK_BYTES    = 12,
  parameter int QUEUE_DEPTH    = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_wdata,
  sb64fe_payload_if.sink  payload,
  sb64fe_text_if.source   text
);

  logic  q_push;
  qent_t q_data;
  logic  q_full;
  logic  q_pop;
  logic  q_head_valid;
  qent_t q_head;

  sb64fe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .payload   (payload),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  sb64fe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head)
  );

  sb64fe_back #(
    .MAX_LINE_CHARS (MAX_LINE_CHARS),
    .CHUNK_BYTES    (CHUNK_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_data  (q_head),
    .pop        (q_pop),
    .text       (text)
  );

endmodule
